@@ src/pixel_ground_plane_backprojection_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the ground plane backprojection checkers.
// ----------------------------------------------------------------------------
`ifndef PIXEL_GROUND_PLANE_BACKPROJECTION_MACROS_SVH
`define PIXEL_GROUND_PLANE_BACKPROJECTION_MACROS_SVH

// same-cycle implication, sampled on clk_i, idle in reset
`define PGPB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgpb check failed");

// next-cycle implication, sampled on clk_i, idle in reset
`define PGPB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgpb check failed");

`endif

@@ src/pgpb_pkg.sv @@
// ----------------------------------------------------------------------------
// Ground plane backprojection package
// Types, register codes, status codes and widths shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgpb_pkg;

  localparam int FocalMin   = 16;
  localparam int GrazeDiv   = 1000000;
  localparam int ShiftLimit = 40;

  // divider and root widths
  localparam int RayNumW   = 33;
  localparam int RayDenW   = 20;
  localparam int RootInW   = 58;
  localparam int PlaceNumW = 61;
  localparam int PlaceDenW = 40;

  typedef enum logic [1:0] {
    CFG_FOCAL_X  = 2'd0,
    CFG_FOCAL_Y  = 2'd1,
    CFG_CENTER_X = 2'd2,
    CFG_CENTER_Y = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_HEIGHT = 2'd1,
    ST_RAY    = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [20:0] h;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [23:0] cn;
    logic signed [23:0] ce;
    logic signed [23:0] cd;
    logic               neg_x;
  } ray_side_t;

  typedef struct packed {
    logic signed [63:0] rx;
    logic signed [63:0] ry;
    logic signed [63:0] rz;
    logic        [32:0] d;
    logic signed [20:0] h;
    logic signed [23:0] cn;
    logic signed [23:0] ce;
    logic signed [23:0] cd;
  } root_side_t;

  typedef struct packed {
    logic signed [20:0] h;
    logic signed [23:0] cn;
    logic signed [23:0] ce;
    logic signed [23:0] cd;
    logic               neg_x;
    logic               neg_y;
  } trail_t;

  typedef struct packed {
    logic signed [23:0] cn;
    logic               neg_x;
    status_e            status;
    logic signed [31:0] gd;
  } north_side_t;

  typedef struct packed {
    logic signed [23:0] ce;
    logic               neg_y;
  } east_side_t;

  function automatic logic signed [31:0] sat32(input logic signed [62:0] v);
    logic signed [31:0] r;
    if (v > 63'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -63'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/pgpb_if.sv @@
// ----------------------------------------------------------------------------
// Ground plane backprojection channels
// Valid/ready request and result channels with their payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pgpb_in_if;
  logic               valid;
  logic               ready;
  logic        [11:0] pixel_col;
  logic        [11:0] pixel_row;
  logic signed [20:0] height_mm;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [23:0] cam_north;
  logic signed [23:0] cam_east;
  logic signed [23:0] cam_down;

  modport source (
    output valid, pixel_col, pixel_row, height_mm, quat_w, quat_x, quat_y, quat_z,
           cam_north, cam_east, cam_down,
    input  ready
  );
  modport sink (
    input  valid, pixel_col, pixel_row, height_mm, quat_w, quat_x, quat_y, quat_z,
           cam_north, cam_east, cam_down,
    output ready
  );
endinterface

interface pgpb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ground_north;
  logic signed [31:0] ground_east;
  logic signed [31:0] ground_down;
  logic        [1:0]  status;

  modport source (
    output valid, ground_north, ground_east, ground_down, status,
    input  ready
  );
  modport sink (
    input  valid, ground_north, ground_east, ground_down, status,
    output ready
  );
endinterface

`default_nettype wire

@@ src/pgpb_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, unsigned, with a sideband that travels along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgpb_div #(
  parameter int NW = 33,
  parameter int DW = 20,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic      [NW-1:0] quo_o,
  output logic      [SW-1:0] side_o
);

  logic          vld_q  [NW];
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] num_q  [NW];
  logic [NW-1:0] quo_q  [NW];
  logic [DW-1:0] den_q  [NW];
  logic [SW-1:0] side_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [NW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fit;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign quo_in  = quo_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, num_in[NW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fit   = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= fit ? diff[DW-1:0] : trial[DW-1:0];
        num_q[s]  <= {num_in[NW-2:0], 1'b0};
        quo_q[s]  <= {quo_in[NW-2:0], fit};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign side_o  = side_q[NW-1];

endmodule

`default_nettype wire

@@ src/pgpb_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor of the root, with a traveling sideband.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgpb_isqrt #(
  parameter int NW = 58,
  parameter int SW = 1,
  localparam int RW = NW / 2
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic      [RW-1:0] root_o,
  output logic      [SW-1:0] side_o
);

  logic          vld_q  [RW];
  logic [RW+1:0] rem_q  [RW];
  logic [NW-1:0] num_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [SW-1:0] side_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic          vld_in;
    logic [RW+1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [RW-1:0] root_in;
    logic [SW-1:0] side_in;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          fit;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign cur   = {rem_in[RW-1:0], num_in[NW-1:NW-2]};
    assign trial = {root_in, 2'b01};
    assign fit   = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= fit ? (cur - trial) : cur;
        num_q[s]  <= {num_in[NW-3:0], 2'b00};
        root_q[s] <= {root_in[RW-2:0], fit};
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

`default_nettype wire

@@ src/pixel_ground_plane_backprojection.sv @@
// One request per cycle sustained while no result is stalled at the output.
// Stages: ray dividers 33, quaternion rotation 4, ray norm root 29,
// grazing test and scaling 6, placement dividers 61, output register 1.
// A stalled result holds the whole pipeline; nothing is lost or repeated.
// Reset clears all valid bits and loads the default camera intrinsics.
// ----------------------------------------------------------------------------
// Pixel ground plane backprojection
// Pinhole ray from intrinsics, quaternion rotation, NED ground intersection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pixel_ground_plane_backprojection (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [19:0] cfg_data_i,
  pgpb_in_if.sink          in_req,
  pgpb_out_if.source       out_res
);

  // configuration
  logic [19:0] focal_x_q, focal_y_q;
  logic [15:0] center_x_q, center_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= 20'd8000;
      focal_y_q  <= 20'd8000;
      center_x_q <= 16'd5120;
      center_y_q <= 16'd3840;
    end else if (cfg_we_i) begin
      unique case (pgpb_pkg::cfg_idx_e'(cfg_idx_i))
        pgpb_pkg::CFG_FOCAL_X:  focal_x_q  <= cfg_data_i;
        pgpb_pkg::CFG_FOCAL_Y:  focal_y_q  <= cfg_data_i;
        pgpb_pkg::CFG_CENTER_X: center_x_q <= cfg_data_i[15:0];
        pgpb_pkg::CFG_CENTER_Y: center_y_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic en;

  assign en           = !out_vld_q || out_res.ready;
  assign in_req.ready = en;

  // ray setup
  logic        [19:0] fx_eff, fy_eff;
  logic signed [17:0] dx, dy;
  logic        [17:0] dx_mag, dy_mag;
  logic [pgpb_pkg::RayNumW-1:0] num_x, num_y;
  pgpb_pkg::ray_side_t ray_side_d;

  always_comb begin
    fx_eff = (focal_x_q < 20'(pgpb_pkg::FocalMin)) ? 20'(pgpb_pkg::FocalMin) : focal_x_q;
    fy_eff = (focal_y_q < 20'(pgpb_pkg::FocalMin)) ? 20'(pgpb_pkg::FocalMin) : focal_y_q;
    dx     = $signed({2'b00, in_req.pixel_col, 4'b0000}) - $signed({2'b00, center_x_q});
    dy     = $signed({2'b00, in_req.pixel_row, 4'b0000}) - $signed({2'b00, center_y_q});
    dx_mag = dx[17] ? 18'(-dx) : 18'(dx);
    dy_mag = dy[17] ? 18'(-dy) : 18'(dy);
    num_x  = {dx_mag[16:0], 16'h0000} + {14'd0, fx_eff[19:1]};
    num_y  = {dy_mag[16:0], 16'h0000} + {14'd0, fy_eff[19:1]};
    ray_side_d.h     = in_req.height_mm;
    ray_side_d.qw    = in_req.quat_w;
    ray_side_d.qx    = in_req.quat_x;
    ray_side_d.qy    = in_req.quat_y;
    ray_side_d.qz    = in_req.quat_z;
    ray_side_d.cn    = in_req.cam_north;
    ray_side_d.ce    = in_req.cam_east;
    ray_side_d.cd    = in_req.cam_down;
    ray_side_d.neg_x = dx[17];
  end

  logic                          div_a_vld, div_b_vld;
  logic [pgpb_pkg::RayNumW-1:0]  quo_a, quo_b;
  pgpb_pkg::ray_side_t           ray_side;
  logic                          neg_y_ray;

  pgpb_div #(
    .NW (pgpb_pkg::RayNumW),
    .DW (pgpb_pkg::RayDenW),
    .SW ($bits(pgpb_pkg::ray_side_t))
  ) u_div_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_req.valid),
    .num_i   (num_x),
    .den_i   (fx_eff),
    .side_i  (ray_side_d),
    .valid_o (div_a_vld),
    .quo_o   (quo_a),
    .side_o  (ray_side)
  );

  pgpb_div #(
    .NW (pgpb_pkg::RayNumW),
    .DW (pgpb_pkg::RayDenW),
    .SW (1)
  ) u_div_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_req.valid),
    .num_i   (num_y),
    .den_i   (fy_eff),
    .side_i  (dy[17]),
    .valid_o (div_b_vld),
    .quo_o   (quo_b),
    .side_o  (neg_y_ray)
  );

  // E1: quaternion products and ray squares
  logic signed [28:0] ray_a, ray_b;
  logic signed [57:0] sq_a, sq_b;

  always_comb begin
    ray_a = ray_side.neg_x ? -$signed({1'b0, quo_a[27:0]}) : $signed({1'b0, quo_a[27:0]});
    ray_b = neg_y_ray      ? -$signed({1'b0, quo_b[27:0]}) : $signed({1'b0, quo_b[27:0]});
    sq_a  = 58'(ray_a) * 58'(ray_a);
    sq_b  = 58'(ray_b) * 58'(ray_b);
  end

  logic               e1_vld_q;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic        [56:0] e1_aa_q, e1_bb_q;
  logic signed [28:0] e1_a_q, e1_b_q;
  logic signed [20:0] e1_h_q;
  logic signed [23:0] e1_cn_q, e1_ce_q, e1_cd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_vld_q <= 1'b0;
    end else if (en) begin
      e1_vld_q <= div_a_vld && div_b_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q    <= 32'(ray_side.qw) * 32'(ray_side.qw);
      xx_q    <= 32'(ray_side.qx) * 32'(ray_side.qx);
      yy_q    <= 32'(ray_side.qy) * 32'(ray_side.qy);
      zz_q    <= 32'(ray_side.qz) * 32'(ray_side.qz);
      xy_q    <= 32'(ray_side.qx) * 32'(ray_side.qy);
      xz_q    <= 32'(ray_side.qx) * 32'(ray_side.qz);
      yz_q    <= 32'(ray_side.qy) * 32'(ray_side.qz);
      wx_q    <= 32'(ray_side.qw) * 32'(ray_side.qx);
      wy_q    <= 32'(ray_side.qw) * 32'(ray_side.qy);
      wz_q    <= 32'(ray_side.qw) * 32'(ray_side.qz);
      e1_aa_q <= sq_a[56:0];
      e1_bb_q <= sq_b[56:0];
      e1_a_q  <= ray_a;
      e1_b_q  <= ray_b;
      e1_h_q  <= ray_side.h;
      e1_cn_q <= ray_side.cn;
      e1_ce_q <= ray_side.ce;
      e1_cd_q <= ray_side.cd;
    end
  end

  // E2: scaled rotation matrix, quaternion norm, ray norm squared
  logic               e2_vld_q;
  logic signed [33:0] e2_m_q [3][3];
  logic signed [33:0] e2_m_d [3][3];
  logic        [32:0] e2_d_q;
  logic        [57:0] e2_n2_q;
  logic signed [28:0] e2_a_q, e2_b_q;
  logic signed [20:0] e2_h_q;
  logic signed [23:0] e2_cn_q, e2_ce_q, e2_cd_q;

  always_comb begin
    e2_m_d[0][0] = 34'(ww_q) + 34'(xx_q) - 34'(yy_q) - 34'(zz_q);
    e2_m_d[0][1] = (34'(xy_q) - 34'(wz_q)) <<< 1;
    e2_m_d[0][2] = (34'(xz_q) + 34'(wy_q)) <<< 1;
    e2_m_d[1][0] = (34'(xy_q) + 34'(wz_q)) <<< 1;
    e2_m_d[1][1] = 34'(ww_q) - 34'(xx_q) + 34'(yy_q) - 34'(zz_q);
    e2_m_d[1][2] = (34'(yz_q) - 34'(wx_q)) <<< 1;
    e2_m_d[2][0] = (34'(xz_q) - 34'(wy_q)) <<< 1;
    e2_m_d[2][1] = (34'(yz_q) + 34'(wx_q)) <<< 1;
    e2_m_d[2][2] = 34'(ww_q) - 34'(xx_q) - 34'(yy_q) + 34'(zz_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e2_vld_q <= 1'b0;
    end else if (en) begin
      e2_vld_q <= e1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_m_q  <= e2_m_d;
      e2_d_q  <= 33'(ww_q[30:0]) + 33'(xx_q[30:0]) + 33'(yy_q[30:0]) + 33'(zz_q[30:0]);
      e2_n2_q <= 58'(e1_aa_q) + 58'(e1_bb_q) + (58'd1 << 32);
      e2_a_q  <= e1_a_q;
      e2_b_q  <= e1_b_q;
      e2_h_q  <= e1_h_q;
      e2_cn_q <= e1_cn_q;
      e2_ce_q <= e1_ce_q;
      e2_cd_q <= e1_cd_q;
    end
  end

  // E3: matrix times ray
  logic               e3_vld_q;
  logic signed [63:0] e3_p_q [3][3];
  logic signed [63:0] e3_p_d [3][3];
  logic        [32:0] e3_d_q;
  logic        [57:0] e3_n2_q;
  logic signed [20:0] e3_h_q;
  logic signed [23:0] e3_cn_q, e3_ce_q, e3_cd_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e3_p_d[i][0] = 64'(63'(e2_m_q[i][0]) * 63'(e2_a_q));
      e3_p_d[i][1] = 64'(63'(e2_m_q[i][1]) * 63'(e2_b_q));
      e3_p_d[i][2] = 64'(e2_m_q[i][2]) <<< 16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e3_vld_q <= 1'b0;
    end else if (en) begin
      e3_vld_q <= e2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_p_q  <= e3_p_d;
      e3_d_q  <= e2_d_q;
      e3_n2_q <= e2_n2_q;
      e3_h_q  <= e2_h_q;
      e3_cn_q <= e2_cn_q;
      e3_ce_q <= e2_ce_q;
      e3_cd_q <= e2_cd_q;
    end
  end

  // E4: world ray sums
  logic                 e4_vld_q;
  logic        [57:0]   e4_n2_q;
  pgpb_pkg::root_side_t e4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e4_vld_q <= 1'b0;
    end else if (en) begin
      e4_vld_q <= e3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e4_side_q.rx <= e3_p_q[0][0] + e3_p_q[0][1] + e3_p_q[0][2];
      e4_side_q.ry <= e3_p_q[1][0] + e3_p_q[1][1] + e3_p_q[1][2];
      e4_side_q.rz <= e3_p_q[2][0] + e3_p_q[2][1] + e3_p_q[2][2];
      e4_side_q.d  <= e3_d_q;
      e4_side_q.h  <= e3_h_q;
      e4_side_q.cn <= e3_cn_q;
      e4_side_q.ce <= e3_ce_q;
      e4_side_q.cd <= e3_cd_q;
      e4_n2_q      <= e3_n2_q;
    end
  end

  logic                             root_vld;
  logic [pgpb_pkg::RootInW/2-1:0]   root;
  pgpb_pkg::root_side_t             root_side;

  pgpb_isqrt #(
    .NW (pgpb_pkg::RootInW),
    .SW ($bits(pgpb_pkg::root_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e4_vld_q),
    .num_i   (e4_n2_q),
    .side_i  (e4_side_q),
    .valid_o (root_vld),
    .root_o  (root),
    .side_o  (root_side)
  );

  // F1: grazing limit products and magnitudes
  logic               f1_vld_q;
  logic        [61:0] f1_p_q;
  logic        [50:0] f1_lo_q, f1_hi_q;
  logic        [61:0] f1_mx_q, f1_my_q, f1_mz_q;
  logic               f1_rz_pos_q, f1_dzero_q;
  pgpb_pkg::trail_t   f1_tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= root_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_p_q        <= 62'(root_side.d) * 62'(root);
      f1_lo_q       <= 51'(root_side.rz[30:0]) * 51'(pgpb_pkg::GrazeDiv);
      f1_hi_q       <= 51'(root_side.rz[61:31]) * 51'(pgpb_pkg::GrazeDiv);
      f1_mx_q       <= root_side.rx[63] ? 62'(-root_side.rx) : root_side.rx[61:0];
      f1_my_q       <= root_side.ry[63] ? 62'(-root_side.ry) : root_side.ry[61:0];
      f1_mz_q       <= root_side.rz[61:0];
      f1_rz_pos_q   <= !root_side.rz[63] && (root_side.rz != 64'sd0);
      f1_dzero_q    <= (root_side.d == 33'd0);
      f1_tr_q.h     <= root_side.h;
      f1_tr_q.cn    <= root_side.cn;
      f1_tr_q.ce    <= root_side.ce;
      f1_tr_q.cd    <= root_side.cd;
      f1_tr_q.neg_x <= root_side.rx[63];
      f1_tr_q.neg_y <= root_side.ry[63];
    end
  end

  // F2: grazing test, status, largest magnitude
  logic [81:0] scaled_rz;
  logic [61:0] mxy;
  pgpb_pkg::status_e f2_status_d;

  always_comb begin
    scaled_rz = {f1_hi_q, 31'd0} + 82'(f1_lo_q);
    mxy       = (f1_mx_q > f1_my_q) ? f1_mx_q : f1_my_q;
    if (f1_tr_q.h[20] || (f1_tr_q.h == 21'sd0)) begin
      f2_status_d = pgpb_pkg::ST_HEIGHT;
    end else if (f1_dzero_q || !f1_rz_pos_q || (scaled_rz < 82'(f1_p_q))) begin
      f2_status_d = pgpb_pkg::ST_RAY;
    end else begin
      f2_status_d = pgpb_pkg::ST_OK;
    end
  end

  logic              f2_vld_q;
  logic       [61:0] f2_mx_q, f2_my_q, f2_mz_q, f2_mm_q;
  pgpb_pkg::status_e f2_status_q;
  pgpb_pkg::trail_t  f2_tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f2_mx_q     <= f1_mx_q;
      f2_my_q     <= f1_my_q;
      f2_mz_q     <= f1_mz_q;
      f2_mm_q     <= (f1_mz_q > mxy) ? f1_mz_q : mxy;
      f2_status_q <= f2_status_d;
      f2_tr_q     <= f1_tr_q;
    end
  end

  // F3: common right shift
  logic [4:0] shift_d;

  always_comb begin
    shift_d = '0;
    for (int i = pgpb_pkg::ShiftLimit; i < 62; i++) begin
      if (f2_mm_q[i]) begin
        shift_d = 5'(i - pgpb_pkg::ShiftLimit + 1);
      end
    end
  end

  logic              f3_vld_q;
  logic       [61:0] f3_mx_q, f3_my_q, f3_mz_q;
  logic       [4:0]  f3_k_q;
  pgpb_pkg::status_e f3_status_q;
  pgpb_pkg::trail_t  f3_tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_vld_q <= 1'b0;
    end else if (en) begin
      f3_vld_q <= f2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f3_mx_q     <= f2_mx_q;
      f3_my_q     <= f2_my_q;
      f3_mz_q     <= f2_mz_q;
      f3_k_q      <= shift_d;
      f3_status_q <= f2_status_q;
      f3_tr_q     <= f2_tr_q;
    end
  end

  // F4: apply shift
  logic [61:0] sh_x, sh_y, sh_z;

  assign sh_x = f3_mx_q >> f3_k_q;
  assign sh_y = f3_my_q >> f3_k_q;
  assign sh_z = f3_mz_q >> f3_k_q;

  logic              f4_vld_q;
  logic       [39:0] f4_sx_q, f4_sy_q, f4_sz_q;
  pgpb_pkg::status_e f4_status_q;
  pgpb_pkg::trail_t  f4_tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f4_vld_q <= 1'b0;
    end else if (en) begin
      f4_vld_q <= f3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f4_sx_q     <= sh_x[39:0];
      f4_sy_q     <= sh_y[39:0];
      f4_sz_q     <= sh_z[39:0];
      f4_status_q <= f3_status_q;
      f4_tr_q     <= f3_tr_q;
    end
  end

  // F5: height times shifted magnitudes, split in halves
  logic              f5_vld_q;
  logic       [39:0] f5_xlo_q, f5_xhi_q, f5_ylo_q, f5_yhi_q;
  logic       [39:0] f5_sz_q;
  pgpb_pkg::status_e f5_status_q;
  pgpb_pkg::trail_t  f5_tr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f5_vld_q <= 1'b0;
    end else if (en) begin
      f5_vld_q <= f4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f5_xlo_q <= 40'(f4_tr_q.h[19:0]) * 40'(f4_sx_q[19:0]);
      f5_xhi_q <= 40'(f4_tr_q.h[19:0]) * 40'(f4_sx_q[39:20]);
      f5_ylo_q <= 40'(f4_tr_q.h[19:0]) * 40'(f4_sy_q[19:0]);
      f5_yhi_q <= 40'(f4_tr_q.h[19:0]) * 40'(f4_sy_q[39:20]);
      f5_sz_q  <= f4_sz_q;
      if ((f4_status_q == pgpb_pkg::ST_OK) && (f4_sz_q == 40'd0)) begin
        f5_status_q <= pgpb_pkg::ST_RAY;
      end else begin
        f5_status_q <= f4_status_q;
      end
      f5_tr_q <= f4_tr_q;
    end
  end

  // F6: rounded placement numerators
  logic                            f6_vld_q;
  logic [pgpb_pkg::PlaceNumW-1:0]  f6_nx_q, f6_ny_q;
  logic [pgpb_pkg::PlaceDenW-1:0]  f6_sz_q;
  pgpb_pkg::north_side_t           f6_nside_q;
  pgpb_pkg::east_side_t            f6_eside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f6_vld_q <= 1'b0;
    end else if (en) begin
      f6_vld_q <= f5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f6_nx_q <= 61'({f5_xhi_q, 20'd0}) + 61'(f5_xlo_q) + 61'(f5_sz_q[39:1]);
      f6_ny_q <= 61'({f5_yhi_q, 20'd0}) + 61'(f5_ylo_q) + 61'(f5_sz_q[39:1]);
      f6_sz_q <= f5_sz_q;
      f6_nside_q.cn     <= f5_tr_q.cn;
      f6_nside_q.neg_x  <= f5_tr_q.neg_x;
      f6_nside_q.status <= f5_status_q;
      f6_nside_q.gd     <= 32'(f5_tr_q.cd) + 32'(f5_tr_q.h);
      f6_eside_q.ce     <= f5_tr_q.ce;
      f6_eside_q.neg_y  <= f5_tr_q.neg_y;
    end
  end

  logic                           div_n_vld, div_e_vld;
  logic [pgpb_pkg::PlaceNumW-1:0] quo_n, quo_e;
  pgpb_pkg::north_side_t          nside;
  pgpb_pkg::east_side_t           eside;

  pgpb_div #(
    .NW (pgpb_pkg::PlaceNumW),
    .DW (pgpb_pkg::PlaceDenW),
    .SW ($bits(pgpb_pkg::north_side_t))
  ) u_div_n (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f6_vld_q),
    .num_i   (f6_nx_q),
    .den_i   (f6_sz_q),
    .side_i  (f6_nside_q),
    .valid_o (div_n_vld),
    .quo_o   (quo_n),
    .side_o  (nside)
  );

  pgpb_div #(
    .NW (pgpb_pkg::PlaceNumW),
    .DW (pgpb_pkg::PlaceDenW),
    .SW ($bits(pgpb_pkg::east_side_t))
  ) u_div_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f6_vld_q),
    .num_i   (f6_ny_q),
    .den_i   (f6_sz_q),
    .side_i  (f6_eside_q),
    .valid_o (div_e_vld),
    .quo_o   (quo_e),
    .side_o  (eside)
  );

  // output register
  logic signed [62:0] sum_n, sum_e;
  logic               ok;

  always_comb begin
    sum_n = nside.neg_x ? (63'(nside.cn) - $signed({2'b00, quo_n}))
                        : (63'(nside.cn) + $signed({2'b00, quo_n}));
    sum_e = eside.neg_y ? (63'(eside.ce) - $signed({2'b00, quo_e}))
                        : (63'(eside.ce) + $signed({2'b00, quo_e}));
    ok    = (nside.status == pgpb_pkg::ST_OK);
  end

  logic signed [31:0] out_north_q, out_east_q, out_down_q;
  logic        [1:0]  out_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_n_vld && div_e_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_north_q  <= ok ? pgpb_pkg::sat32(sum_n) : 32'sd0;
      out_east_q   <= ok ? pgpb_pkg::sat32(sum_e) : 32'sd0;
      out_down_q   <= ok ? nside.gd : 32'sd0;
      out_status_q <= nside.status;
    end
  end

  assign out_res.valid        = out_vld_q;
  assign out_res.ground_north = out_north_q;
  assign out_res.ground_east  = out_east_q;
  assign out_res.ground_down  = out_down_q;
  assign out_res.status       = out_status_q;

endmodule

`default_nettype wire

@@ src/pgpb_checker.sv @@
// ----------------------------------------------------------------------------
// Ground plane backprojection checker
// Port-level properties of the backprojection block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_ground_plane_backprojection_macros.svh"

module pgpb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_north_i,
  input wire logic [31:0] out_east_i,
  input wire logic [31:0] out_down_i,
  input wire logic [1:0]  out_status_i
);

  // hold a stalled result
  `PGPB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result blocks new requests
  `PGPB_ASSERT_NOW(a_stall_blocks_in, out_valid_i && !out_ready_i, !in_ready_i)

  // an empty output side takes requests
  `PGPB_ASSERT_NOW(a_idle_takes_in, !out_valid_i, in_ready_i)

  // error results carry zero coordinates
  `PGPB_ASSERT_NOW(a_err_zero, out_valid_i && (out_status_i != pgpb_pkg::ST_OK),
                   (out_north_i == 32'd0) && (out_east_i == 32'd0) && (out_down_i == 32'd0))

endmodule

bind pixel_ground_plane_backprojection pgpb_checker u_pgpb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_req.ready),
  .out_valid_i  (out_res.valid),
  .out_ready_i  (out_res.ready),
  .out_north_i  (out_res.ground_north),
  .out_east_i   (out_res.ground_east),
  .out_down_i   (out_res.ground_down),
  .out_status_i (out_res.status)
);

`default_nettype wire
